// ----- sv/itmh_pkg.sv -----
`default_nettype none

package itmh_pkg;

  localparam int unsigned NUM_IDS = 64;
  localparam int unsigned ID_W    = 6;
  localparam int unsigned TMO_W   = 16;
  localparam logic [TMO_W-1:0] TMO_RESET = 16'd60;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_TOUCH  = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_SWEEP  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_BAD     = 3'd2,
    ST_EXPIRED = 3'd3,
    ST_NONE    = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_DISP,
    S_LD_RD,
    S_LD_US,
    S_UP_RD,
    S_UP_CMP,
    S_DN_L,
    S_DN_LC,
    S_DN_RC,
    S_FINAL,
    S_SW_RD,
    S_SW_CK,
    S_SW_DEL,
    S_EMIT
  } state_e;

endpackage

`default_nettype wire

// ----- sv/itmh_store.sv -----
`default_nettype none

module itmh_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned PW    = 6,
  parameter int unsigned TW    = 32
) (
  input  wire logic                       clk_i,
  input  wire logic [PW-1:0]              heap_raddr_i,
  input  wire logic                       heap_we_i,
  input  wire logic [PW-1:0]              heap_waddr_i,
  input  wire logic [itmh_pkg::ID_W-1:0]  heap_wid_i,
  input  wire logic [TW-1:0]              heap_wt_i,
  output logic      [itmh_pkg::ID_W-1:0]  heap_rid_o,
  output logic      [TW-1:0]              heap_rt_o,
  input  wire logic [itmh_pkg::ID_W-1:0]  slot_raddr_i,
  input  wire logic                       slot_we_i,
  input  wire logic [itmh_pkg::ID_W-1:0]  slot_waddr_i,
  input  wire logic [PW-1:0]              slot_wdata_i,
  output logic      [PW-1:0]              slot_rdata_o
);

  logic [itmh_pkg::ID_W-1:0] ids_mem   [DEPTH];
  logic [TW-1:0]             times_mem [DEPTH];
  logic [PW-1:0]             slot_mem  [itmh_pkg::NUM_IDS];

  // heap entries: one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (heap_we_i) begin
      ids_mem[heap_waddr_i]   <= heap_wid_i;
      times_mem[heap_waddr_i] <= heap_wt_i;
    end
    heap_rid_o <= ids_mem[heap_raddr_i];
    heap_rt_o  <= times_mem[heap_raddr_i];
  end

  // id to slot map
  always_ff @(posedge clk_i) begin
    if (slot_we_i) begin
      slot_mem[slot_waddr_i] <= slot_wdata_i;
    end
    slot_rdata_o <= slot_mem[slot_raddr_i];
  end

endmodule

`default_nettype wire

// ----- sv/itmh_cmp.sv -----
`default_nettype none

module itmh_cmp #(
  parameter int unsigned W = 33
) (
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] b_i,
  output logic              lt_o
);

  // shared magnitude compare, used by every sift step and the expiry test
  assign lt_o = (a_i < b_i);

endmodule

`default_nettype wire

// ----- sv/idle_timeout_min_heap_unit.sv -----
`default_nettype none

// Idle-timeout queue: a binary min-heap of connection ids ordered by stamp.
// Input channel (in_valid_i/in_ready_o) takes one command beat: insert,
// touch, remove or sweep, with conn_id_i and now_i. Output channel
// (out_valid_o/out_ready_i) returns result beats; insert, touch and remove
// give one beat, sweep gives one beat per expired id (last_o on the final
// one) or a single "none expired" beat.
// The block works on one command at a time and is not ready meanwhile.
// A command passes through lookup (accept, slot and root read, dispatch),
// sift-up (read parent, compare) and sift-down (read left child, compare
// it, compare right child) level by level, a fetch of the last entry on a
// remove, then the final write and the beat hand-off. A sweep repeats the
// fetch and sift-down for each popped id. The pace is set by the single
// read port of the heap memory and the one shared comparator.
// The user must write the idle timeout register through cfg_we_i/cfg_wdata_i
// only while idle; the block itself does not enforce it. Reset empties the queue
// (presence bits and count) and sets the timeout to 60. A stalled receiver holds
// the result beat in the output register; the sequencer waits before writing the
// next beat, and the next command may be taken while the last beat still waits.
module idle_timeout_min_heap_unit #(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [itmh_pkg::TMO_W-1:0]   cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [1:0]                   command_i,
  input  wire logic [itmh_pkg::ID_W-1:0]    conn_id_i,
  input  wire logic [31:0]                  now_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [itmh_pkg::ID_W-1:0]    result_id_o,
  output logic      [2:0]                   status_o,
  output logic                              last_o
);

  localparam int unsigned LIMIT = (CAPACITY < itmh_pkg::NUM_IDS) ? CAPACITY
                                                                 : itmh_pkg::NUM_IDS;
  localparam int unsigned PW = $clog2(LIMIT);
  localparam int unsigned CW = $clog2(LIMIT + 1);
  localparam int unsigned XW = PW + 2;
  localparam int unsigned TW = TIME_BITS;
  localparam int unsigned EW = ((TW > itmh_pkg::TMO_W) ? TW : itmh_pkg::TMO_W) + 1;
  localparam int unsigned IW = itmh_pkg::ID_W;

  itmh_pkg::state_e  state_q, state_d, ret_q, ret_d;
  itmh_pkg::cmd_e    cmd_q;
  itmh_pkg::status_e em_st_q, em_st_d, out_st_q;
  logic [IW-1:0]     id_q, cur_id_q, cur_id_d, lt_id_q, lt_id_d, root_id_q, root_id_d;
  logic [IW-1:0]     pend_id_q, pend_id_d, em_id_q, em_id_d, out_id_q;
  logic [TW-1:0]     now_q, cur_t_q, cur_t_d, lt_t_q, lt_t_d, now_t;
  logic [PW-1:0]     pos_q, pos_d;
  logic [CW-1:0]     count_q, count_d;
  logic [itmh_pkg::NUM_IDS-1:0] present_q, present_d;
  logic [itmh_pkg::TMO_W-1:0]   tmo_q;
  logic              bsel_q, bsel_d, has_pend_q, has_pend_d, do_down_q, do_down_d;
  logic              em_last_q, em_last_d, out_valid_q, out_last_q, out_load;
  logic              accept;

  // store interface
  logic [PW-1:0]     heap_raddr, heap_waddr, slot_rdata, slot_wdata;
  logic              heap_we, slot_we;
  logic [IW-1:0]     heap_wid, heap_rid, slot_waddr;
  logic [TW-1:0]     heap_wt, heap_rt;

  // compare unit
  logic [EW-1:0]     cmp_a, cmp_b;
  logic              cmp_lt;

  // index arithmetic
  logic [PW-1:0]     parent;
  logic [XW-1:0]     lchild, rchild, count_x;

  assign now_t   = TW'(now_i);
  assign accept  = in_valid_i && in_ready_o;
  assign parent  = PW'((pos_q - PW'(1)) >> 1);
  assign lchild  = {1'b0, pos_q, 1'b1};
  assign rchild  = lchild + XW'(1);
  assign count_x = XW'(count_q);

  itmh_store #(.DEPTH(LIMIT), .PW(PW), .TW(TW)) u_store (
    .clk_i        (clk_i),
    .heap_raddr_i (heap_raddr),
    .heap_we_i    (heap_we),
    .heap_waddr_i (heap_waddr),
    .heap_wid_i   (heap_wid),
    .heap_wt_i    (heap_wt),
    .heap_rid_o   (heap_rid),
    .heap_rt_o    (heap_rt),
    .slot_raddr_i (id_q),
    .slot_we_i    (slot_we),
    .slot_waddr_i (slot_waddr),
    .slot_wdata_i (slot_wdata),
    .slot_rdata_o (slot_rdata)
  );

  itmh_cmp #(.W(EW)) u_cmp (
    .a_i  (cmp_a),
    .b_i  (cmp_b),
    .lt_o (cmp_lt)
  );

  // steer the shared comparator
  always_comb begin
    cmp_a = EW'(cur_t_q);
    cmp_b = EW'(heap_rt);
    case (state_q)
      itmh_pkg::S_DN_LC: begin
        cmp_a = EW'(heap_rt);
        cmp_b = EW'(cur_t_q);
      end
      itmh_pkg::S_DN_RC: begin
        cmp_a = EW'(heap_rt);
        cmp_b = bsel_q ? EW'(lt_t_q) : EW'(cur_t_q);
      end
      itmh_pkg::S_SW_CK: begin
        cmp_a = EW'(now_q);
        cmp_b = EW'(heap_rt) + EW'(tmo_q);
      end
      default: begin
        cmp_a = EW'(cur_t_q);
        cmp_b = EW'(heap_rt);
      end
    endcase
  end

  // sequencer: next state, memory access and beat staging
  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    em_st_d    = em_st_q;
    em_id_d    = em_id_q;
    em_last_d  = em_last_q;
    cur_id_d   = cur_id_q;
    cur_t_d    = cur_t_q;
    lt_id_d    = lt_id_q;
    lt_t_d     = lt_t_q;
    root_id_d  = root_id_q;
    pend_id_d  = pend_id_q;
    has_pend_d = has_pend_q;
    do_down_d  = do_down_q;
    bsel_d     = bsel_q;
    pos_d      = pos_q;
    count_d    = count_q;
    present_d  = present_q;
    heap_raddr = '0;
    heap_we    = 1'b0;
    heap_waddr = pos_q;
    heap_wid   = heap_rid;
    heap_wt    = heap_rt;
    slot_we    = 1'b0;
    slot_waddr = heap_rid;
    slot_wdata = pos_q;
    out_load   = 1'b0;
    in_ready_o = 1'b0;

    case (state_q)
      itmh_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          has_pend_d = 1'b0;
          state_d    = itmh_pkg::S_LOOK;
        end
      end

      // slot of the id and the root are read here
      itmh_pkg::S_LOOK: begin
        heap_raddr = '0;
        state_d    = itmh_pkg::S_DISP;
      end

      itmh_pkg::S_DISP: begin
        em_id_d   = id_q;
        em_last_d = 1'b1;
        ret_d     = itmh_pkg::S_IDLE;
        cur_id_d  = id_q;
        cur_t_d   = now_q;
        case (cmd_q)
          itmh_pkg::CMD_INSERT: begin
            if (present_q[id_q]) begin
              em_st_d = itmh_pkg::ST_BAD;
              state_d = itmh_pkg::S_EMIT;
            end else if (count_q >= CW'(LIMIT)) begin
              em_st_d = itmh_pkg::ST_FULL;
              state_d = itmh_pkg::S_EMIT;
            end else begin
              pos_d           = PW'(count_q);
              count_d         = count_q + CW'(1);
              present_d[id_q] = 1'b1;
              do_down_d       = 1'b0;
              state_d         = itmh_pkg::S_UP_RD;
            end
          end
          itmh_pkg::CMD_TOUCH: begin
            if (!present_q[id_q] || CW'(slot_rdata) >= count_q) begin
              em_st_d = itmh_pkg::ST_BAD;
              state_d = itmh_pkg::S_EMIT;
            end else begin
              pos_d     = slot_rdata;
              do_down_d = 1'b1;
              state_d   = itmh_pkg::S_UP_RD;
            end
          end
          itmh_pkg::CMD_REMOVE: begin
            if (!present_q[id_q] || CW'(slot_rdata) >= count_q) begin
              em_st_d = itmh_pkg::ST_BAD;
              state_d = itmh_pkg::S_EMIT;
            end else begin
              present_d[id_q] = 1'b0;
              count_d         = count_q - CW'(1);
              pos_d           = slot_rdata;
              do_down_d       = 1'b1;
              em_st_d         = itmh_pkg::ST_OK;
              if (CW'(slot_rdata) == count_q - CW'(1)) begin
                state_d = itmh_pkg::S_EMIT;
              end else begin
                state_d = itmh_pkg::S_LD_RD;
              end
            end
          end
          default: begin
            state_d = itmh_pkg::S_SW_RD;
          end
        endcase
      end

      // fetch the last entry into the hole
      itmh_pkg::S_LD_RD: begin
        heap_raddr = PW'(count_q);
        state_d    = itmh_pkg::S_LD_US;
      end

      itmh_pkg::S_LD_US: begin
        cur_id_d = heap_rid;
        cur_t_d  = heap_rt;
        state_d  = itmh_pkg::S_UP_RD;
      end

      // sift up: read parent
      itmh_pkg::S_UP_RD: begin
        heap_raddr = parent;
        if (pos_q == '0) begin
          state_d = do_down_q ? itmh_pkg::S_DN_L : itmh_pkg::S_FINAL;
        end else begin
          state_d = itmh_pkg::S_UP_CMP;
        end
      end

      // move the parent down while it is strictly later
      itmh_pkg::S_UP_CMP: begin
        if (cmp_lt) begin
          heap_we = 1'b1;
          slot_we = 1'b1;
          pos_d   = parent;
          state_d = itmh_pkg::S_UP_RD;
        end else begin
          state_d = do_down_q ? itmh_pkg::S_DN_L : itmh_pkg::S_FINAL;
        end
      end

      // sift down: read left child
      itmh_pkg::S_DN_L: begin
        heap_raddr = lchild[PW-1:0];
        if (lchild >= count_x) begin
          state_d = itmh_pkg::S_FINAL;
        end else begin
          state_d = itmh_pkg::S_DN_LC;
        end
      end

      itmh_pkg::S_DN_LC: begin
        lt_id_d    = heap_rid;
        lt_t_d     = heap_rt;
        bsel_d     = cmp_lt;
        heap_raddr = rchild[PW-1:0];
        if (rchild < count_x) begin
          state_d = itmh_pkg::S_DN_RC;
        end else if (cmp_lt) begin
          heap_we = 1'b1;
          slot_we = 1'b1;
          pos_d   = lchild[PW-1:0];
          state_d = itmh_pkg::S_DN_L;
        end else begin
          state_d = itmh_pkg::S_FINAL;
        end
      end

      itmh_pkg::S_DN_RC: begin
        if (cmp_lt) begin
          heap_we = 1'b1;
          slot_we = 1'b1;
          pos_d   = rchild[PW-1:0];
          state_d = itmh_pkg::S_DN_L;
        end else if (bsel_q) begin
          heap_we    = 1'b1;
          heap_wid   = lt_id_q;
          heap_wt    = lt_t_q;
          slot_we    = 1'b1;
          slot_waddr = lt_id_q;
          pos_d      = lchild[PW-1:0];
          state_d    = itmh_pkg::S_DN_L;
        end else begin
          state_d = itmh_pkg::S_FINAL;
        end
      end

      // drop the moving entry into its slot
      itmh_pkg::S_FINAL: begin
        heap_we    = 1'b1;
        heap_wid   = cur_id_q;
        heap_wt    = cur_t_q;
        slot_we    = 1'b1;
        slot_waddr = cur_id_q;
        if (cmd_q == itmh_pkg::CMD_SWEEP) begin
          state_d = itmh_pkg::S_SW_RD;
        end else begin
          em_st_d = itmh_pkg::ST_OK;
          ret_d   = itmh_pkg::S_IDLE;
          state_d = itmh_pkg::S_EMIT;
        end
      end

      itmh_pkg::S_SW_RD: begin
        heap_raddr = '0;
        state_d    = itmh_pkg::S_SW_CK;
      end

      // expiry test on the root; a held id goes out once its successor is known
      itmh_pkg::S_SW_CK: begin
        root_id_d = heap_rid;
        if (count_q != '0 && !cmp_lt) begin
          if (has_pend_q) begin
            em_id_d   = pend_id_q;
            em_st_d   = itmh_pkg::ST_EXPIRED;
            em_last_d = 1'b0;
            ret_d     = itmh_pkg::S_SW_DEL;
            state_d   = itmh_pkg::S_EMIT;
          end else begin
            state_d = itmh_pkg::S_SW_DEL;
          end
        end else begin
          em_last_d = 1'b1;
          ret_d     = itmh_pkg::S_IDLE;
          state_d   = itmh_pkg::S_EMIT;
          if (has_pend_q) begin
            em_id_d = pend_id_q;
            em_st_d = itmh_pkg::ST_EXPIRED;
          end else begin
            em_id_d = '0;
            em_st_d = itmh_pkg::ST_NONE;
          end
        end
      end

      itmh_pkg::S_SW_DEL: begin
        pend_id_d            = root_id_q;
        has_pend_d           = 1'b1;
        present_d[root_id_q] = 1'b0;
        count_d              = count_q - CW'(1);
        pos_d                = '0;
        do_down_d            = 1'b1;
        if (count_q == CW'(1)) begin
          state_d = itmh_pkg::S_SW_RD;
        end else begin
          state_d = itmh_pkg::S_LD_RD;
        end
      end

      // hand the staged beat to the output register when it is free
      itmh_pkg::S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ret_q;
        end
      end

      default: begin
        state_d = itmh_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= itmh_pkg::S_IDLE;
      count_q     <= '0;
      present_q   <= '0;
      tmo_q       <= itmh_pkg::TMO_RESET;
      out_valid_q <= 1'b0;
      has_pend_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      present_q  <= present_d;
      has_pend_q <= has_pend_d;
      if (cfg_we_i) begin
        tmo_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ret_q     <= ret_d;
    em_st_q   <= em_st_d;
    em_id_q   <= em_id_d;
    em_last_q <= em_last_d;
    cur_id_q  <= cur_id_d;
    cur_t_q   <= cur_t_d;
    lt_id_q   <= lt_id_d;
    lt_t_q    <= lt_t_d;
    root_id_q <= root_id_d;
    pend_id_q <= pend_id_d;
    do_down_q <= do_down_d;
    bsel_q    <= bsel_d;
    pos_q     <= pos_d;
    if (accept) begin
      cmd_q <= itmh_pkg::cmd_e'(command_i);
      id_q  <= conn_id_i;
      now_q <= now_t;
    end
    if (out_load) begin
      out_id_q   <= em_id_q;
      out_st_q   <= em_st_q;
      out_last_q <= em_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_id_o = out_id_q;
  assign status_o    = out_st_q;
  assign last_o      = out_last_q;

endmodule

`default_nettype wire

// ----- sv/itmh_checker.sv -----
`default_nettype none

module itmh_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [5:0] result_id_o,
  input wire logic [2:0] status_o,
  input wire logic       last_o
);

  // one command at a time: no ready straight after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a command is in progress");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_id_o)
      && $stable(status_o) && $stable(last_o))
    else $error("result beat changed under stall");

  // only expired beats may be followed by more beats
  a_last_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != itmh_pkg::ST_EXPIRED |-> last_o)
    else $error("non-expiry beat without last");

  // the empty sweep answer carries id zero
  a_none_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == itmh_pkg::ST_NONE |-> result_id_o == '0)
    else $error("none-expired beat with an id");

endmodule

bind idle_timeout_min_heap_unit itmh_checker u_itmh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .result_id_o (result_id_o),
  .status_o    (status_o),
  .last_o      (last_o)
);

`default_nettype wire

// ----- verif/tb.sv -----
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HEAP_CAP   = 64;
  localparam int          N_RANDOM   = 300;
  localparam longint      CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [itmh_pkg::ID_W-1:0] id;
    itmh_pkg::status_e         status;
    logic                      last;
  } result_t;

  typedef struct {
    itmh_pkg::cmd_e cmd;
    logic [5:0]     id;
    logic [31:0]    now;
    bit             fixed;
    result_t        res;
  } row_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [itmh_pkg::TMO_W-1:0] cfg_wdata_i;
  logic in_valid_i, in_ready_o;
  logic [1:0] command_i;
  logic [itmh_pkg::ID_W-1:0] conn_id_i;
  logic [31:0] now_i;
  logic out_valid_o, out_ready_i;
  logic [itmh_pkg::ID_W-1:0] result_id_o;
  logic [2:0] status_o;
  logic last_o;

  idle_timeout_min_heap_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .command_i, .conn_id_i, .now_i,
    .out_valid_o, .out_ready_i, .result_id_o, .status_o, .last_o
  );

  // Shadow copy of the timer queue
  logic [5:0]  q_ids   [HEAP_CAP];
  logic [31:0] q_stamp [HEAP_CAP];
  int unsigned q_slot  [64];
  bit          q_live  [64];
  int unsigned q_count;
  logic [15:0] q_timeout;

  result_t pending_q[$];
  result_t fixed_q[$];
  int  errors;
  longint cycles;
  int  beats_out, expired_seen;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic void q_put(int unsigned pos, logic [5:0] id, logic [31:0] t);
    q_ids[pos] = id;
    q_stamp[pos] = t;
    q_slot[id] = pos;
  endfunction

  function automatic int unsigned q_up(int unsigned pos);
    logic [5:0] id;
    logic [31:0] t;
    int unsigned par;
    if (pos >= q_count) return pos;
    id = q_ids[pos];
    t = q_stamp[pos];
    while (pos > 0) begin
      par = (pos - 1) / 2;
      if (q_stamp[par] <= t) break;
      q_put(pos, q_ids[par], q_stamp[par]);
      pos = par;
    end
    q_put(pos, id, t);
    return pos;
  endfunction

  function automatic void q_down(int unsigned pos);
    logic [5:0] id;
    logic [31:0] t, bt;
    int unsigned l, r, best;
    if (pos >= q_count) return;
    id = q_ids[pos];
    t = q_stamp[pos];
    forever begin
      l = pos * 2 + 1;
      r = pos * 2 + 2;
      best = pos;
      bt = t;
      if (l < q_count && q_stamp[l] < bt) begin
        best = l;
        bt = q_stamp[l];
      end
      if (r < q_count && q_stamp[r] < bt) best = r;
      if (best == pos) break;
      q_put(pos, q_ids[best], q_stamp[best]);
      pos = best;
    end
    q_put(pos, id, t);
  endfunction

  function automatic void q_delete(int unsigned pos);
    int unsigned lp;
    if (q_count == 0 || pos >= q_count) return;
    q_live[q_ids[pos]] = 0;
    lp = q_count - 1;
    q_count = lp;
    if (pos != lp) begin
      q_put(pos, q_ids[lp], q_stamp[lp]);
      q_down(q_up(pos));
    end
  endfunction

  // Work out the result beats of one command and queue them
  function automatic void predict_timer_cmd(itmh_pkg::cmd_e cmd, logic [5:0] id,
                                            logic [31:0] now);
    result_t r;
    int n;
    n = 0;
    r.id = id;
    r.last = 1'b1;
    case (cmd)
      itmh_pkg::CMD_INSERT: begin
        if (q_live[id]) r.status = itmh_pkg::ST_BAD;
        else if (q_count >= HEAP_CAP) r.status = itmh_pkg::ST_FULL;
        else begin
          q_count++;
          q_live[id] = 1;
          q_put(q_count - 1, id, now);
          void'(q_up(q_count - 1));
          r.status = itmh_pkg::ST_OK;
        end
        pending_q.push_back(r);
      end
      itmh_pkg::CMD_TOUCH: begin
        if (!q_live[id] || q_slot[id] >= q_count) r.status = itmh_pkg::ST_BAD;
        else begin
          q_stamp[q_slot[id]] = now;
          q_down(q_up(q_slot[id]));
          r.status = itmh_pkg::ST_OK;
        end
        pending_q.push_back(r);
      end
      itmh_pkg::CMD_REMOVE: begin
        if (!q_live[id] || q_slot[id] >= q_count) r.status = itmh_pkg::ST_BAD;
        else begin
          q_delete(q_slot[id]);
          r.status = itmh_pkg::ST_OK;
        end
        pending_q.push_back(r);
      end
      default: begin
        while (q_count > 0 && n < 64) begin
          if ({32'd0, q_stamp[0]} + {48'd0, q_timeout} > {32'd0, now}) break;
          r.id = q_ids[0];
          r.status = itmh_pkg::ST_EXPIRED;
          r.last = 1'b0;
          pending_q.push_back(r);
          n++;
          q_delete(0);
        end
        if (n == 0) begin
          r.id = '0;
          r.status = itmh_pkg::ST_NONE;
          r.last = 1'b1;
          pending_q.push_back(r);
        end else begin
          r = pending_q[$];
          r.last = 1'b1;
          pending_q[$] = r;
        end
      end
    endcase
  endfunction

  // Receiver stall pattern
  int stall_mode;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 3) != 0);
        2: out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= (cycles % 7) < 4;
      endcase
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    result_t exp_r, fx;
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_out++;
      if (pending_q.size() == 0) begin
        $error("result beat with nothing expected: id %0d status %0d",
               result_id_o, status_o);
        errors++;
      end else begin
        exp_r = pending_q.pop_front();
        if (fixed_q.size() > 0) begin
          fx = fixed_q.pop_front();
          if (fx != exp_r) begin
            $error("table row disagrees with predictor: %p vs %p", fx, exp_r);
            errors++;
          end
        end
        if (exp_r.status == itmh_pkg::ST_EXPIRED) expired_seen++;
        if (result_id_o !== exp_r.id) begin
          $error("result_id expected %0d actual %0d", exp_r.id, result_id_o);
          errors++;
        end
        if (status_o !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, status_o);
          errors++;
        end
        if (last_o !== exp_r.last) begin
          $error("last expected %0d actual %0d", exp_r.last, last_o);
          errors++;
        end
      end
    end
  end

  // Drop valid and scramble the payload between beats
  task automatic idle_input();
    in_valid_i <= 1'b0;
    command_i <= 2'($urandom);
    conn_id_i <= 6'($urandom);
    now_i <= $urandom;
  endtask

  // Drive one command beat, with a random gap outside bursts
  int burst_left;
  task automatic send_cmd(itmh_pkg::cmd_e cmd, logic [5:0] id, logic [31:0] now);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        idle_input();
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    command_i <= cmd;
    conn_id_i <= id;
    now_i <= now;
    predict_timer_cmd(cmd, id, now);
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
  endtask

  // Drain all expectations, settle, then write the timeout
  task automatic set_timeout(logic [15:0] v);
    idle_input();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    q_timeout = v;
  endtask

  row_t table_rows[$];
  task automatic add_row(itmh_pkg::cmd_e c, logic [5:0] id, logic [31:0] now,
                         bit fixed = 0, itmh_pkg::status_e s = itmh_pkg::ST_OK,
                         logic [5:0] rid = 0);
    row_t w;
    w.cmd = c;
    w.id = id;
    w.now = now;
    w.fixed = fixed;
    w.res.id = rid;
    w.res.status = s;
    w.res.last = 1'b1;
    table_rows.push_back(w);
  endtask

  logic [31:0] clock_now;
  int phase;

  initial begin
    itmh_pkg::cmd_e c;
    logic [5:0] id;
    int pick;
    errors = 0;
    cycles = 0;
    beats_out = 0;
    expired_seen = 0;
    burst_left = 0;
    stall_mode = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    command_i = '0;
    conn_id_i = '0;
    now_i = '0;
    q_count = 0;
    q_timeout = itmh_pkg::TMO_RESET;
    foreach (q_live[i]) q_live[i] = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: errors on empty queue, extremes, ties, wrap-free expiry
    add_row(itmh_pkg::CMD_SWEEP,  6'd0,  32'd0, 1, itmh_pkg::ST_NONE, 6'd0);
    add_row(itmh_pkg::CMD_TOUCH,  6'd63, 32'd5, 1, itmh_pkg::ST_BAD, 6'd63);
    add_row(itmh_pkg::CMD_REMOVE, 6'd0,  32'd5, 1, itmh_pkg::ST_BAD, 6'd0);
    add_row(itmh_pkg::CMD_INSERT, 6'd0,  32'd100, 1, itmh_pkg::ST_OK, 6'd0);
    add_row(itmh_pkg::CMD_INSERT, 6'd0,  32'd100, 1, itmh_pkg::ST_BAD, 6'd0);
    add_row(itmh_pkg::CMD_INSERT, 6'd63, 32'd100);
    add_row(itmh_pkg::CMD_INSERT, 6'd5,  32'd50);
    add_row(itmh_pkg::CMD_INSERT, 6'd7,  32'hFFFF_FFFF);
    add_row(itmh_pkg::CMD_TOUCH,  6'd5,  32'd300);
    add_row(itmh_pkg::CMD_SWEEP,  6'd9,  32'd159, 1, itmh_pkg::ST_NONE, 6'd0);
    add_row(itmh_pkg::CMD_SWEEP,  6'd0,  32'd160);
    add_row(itmh_pkg::CMD_REMOVE, 6'd7,  32'd0, 1, itmh_pkg::ST_OK, 6'd7);
    add_row(itmh_pkg::CMD_REMOVE, 6'd7,  32'd0, 1, itmh_pkg::ST_BAD, 6'd7);
    add_row(itmh_pkg::CMD_INSERT, 6'd1,  32'hFFFF_FFFF);
    add_row(itmh_pkg::CMD_SWEEP,  6'd0,  32'hFFFF_FFFF);
    add_row(itmh_pkg::CMD_SWEEP,  6'd0,  32'hFFFF_FFFF, 1, itmh_pkg::ST_NONE, 6'd0);
    foreach (table_rows[k]) begin
      if (table_rows[k].fixed) begin
        while (fixed_q.size() < pending_q.size())
          fixed_q.push_back(pending_q[fixed_q.size()]);
        send_cmd(table_rows[k].cmd, table_rows[k].id, table_rows[k].now);
        fixed_q.push_back(table_rows[k].res);
      end else begin
        send_cmd(table_rows[k].cmd, table_rows[k].id, table_rows[k].now);
      end
    end
    idle_input();
    while (pending_q.size() != 0) @(posedge clk_i);
    fixed_q.delete();

    // Give every id an entry, then a duplicate insert and a full sweep
    set_timeout(16'd0);
    for (int i = 0; i < 64; i++)
      send_cmd(itmh_pkg::CMD_INSERT, 6'(i), $urandom_range(0, 1000));
    send_cmd(itmh_pkg::CMD_INSERT, 6'd3, 32'd0);
    for (int i = 0; i < 64; i++)
      if (!q_live[i]) send_cmd(itmh_pkg::CMD_INSERT, 6'(i), 32'd0);
    send_cmd(itmh_pkg::CMD_SWEEP, 6'd0, 32'd2000);

    // Random phases under several timeouts and stall patterns
    for (phase = 0; phase < 4; phase++) begin
      set_timeout(phase == 0 ? 16'hFFFF : phase == 1 ? 16'd1 : 16'($urandom));
      stall_mode = phase;
      clock_now = (phase == 0) ? 32'hFFFE_0000 : $urandom_range(0, 1000);
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) clock_now = $urandom;
        else clock_now += $urandom_range(0, (phase == 1) ? 3 : 4000);
        if (pick < 40) c = itmh_pkg::CMD_INSERT;
        else if (pick < 60) c = itmh_pkg::CMD_TOUCH;
        else if (pick < 75) c = itmh_pkg::CMD_REMOVE;
        else c = itmh_pkg::CMD_SWEEP;
        id = 6'($urandom);
        // Bias touch and remove towards live ids
        if ((c == itmh_pkg::CMD_TOUCH || c == itmh_pkg::CMD_REMOVE) && q_count > 0
            && $urandom_range(0, 3) != 0)
          id = q_ids[$urandom_range(0, q_count - 1)];
        send_cmd(c, id, (pick % 17 == 0) ? $urandom : clock_now);
      end
    end
    set_timeout(16'd0);
    send_cmd(itmh_pkg::CMD_SWEEP, 6'd0, 32'hFFFF_FFFF);

    idle_input();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Ran directed rows, every-id fill and random traffic: %0d result beats, %0d expiries.",
             beats_out, expired_seen);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
